// File: rtl/tnt_pkg.sv
package tnt_pkg;

   // Defaults for the top-level parameters
   localparam int POSITION_WIDTH_DEF = 24;
   localparam int TEXCOORD_WIDTH_DEF = 16;
   localparam int UNIT_FRAC_BITS_DEF = 14;

   // Width of every unit vector component on the result channel
   localparam int RES_W = 16;

   // Block-scaled magnitudes keep their top bit at NORM_TOP-1
   localparam int NORM_TOP = 30;
   localparam int ROOT_W   = NORM_TOP + 1;
   localparam int RAD_W    = 2 * ROOT_W;

   // Product step counter of the cross-product, determinant and tangent phase
   localparam int STEP_W = 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_SCALE,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_NEXT,
      ST_OUT
   } state_type;

endpackage

// File: rtl/triangle_normal_tangent.sv
// Triangle face normal and UV tangent.
// Corners arrive on the req_ channel in triangle order, one item each:
// position (signed Q12.12) and texture coordinate (signed Q4.12).
// The first two corners of a triangle are taken and held.
// On the third corner the block computes the edges, the cross product, the
// UV determinant and the tangent combination on one shared multiplier
// (fourteen products), then normalizes each vector: a one-bit-per-cycle
// block-scale shifter (up to 29 shifts), three squares on the multiplier, a
// square root and three divisions. The block takes no new corner until the
// rsp_ item is in the output register; req_ready is low meanwhile.
// One rsp_ item per triangle carries both unit vectors (signed Q1.14) and
// the two degenerate flags; a zero vector gives zeros and a raised flag.
// The result sits in an output register; while the receiver stalls, the
// first two corners of the next triangle are still taken, the third waits.
// Reset clears the corner count, the sequencer and the output valid.
module triangle_normal_tangent #(
   parameter int POSITION_WIDTH = tnt_pkg::POSITION_WIDTH_DEF,
   parameter int TEXCOORD_WIDTH = tnt_pkg::TEXCOORD_WIDTH_DEF,
   parameter int UNIT_FRAC_BITS = tnt_pkg::UNIT_FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_x,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_y,
   input  logic signed [POSITION_WIDTH-1:0] req_pos_z,
   input  logic signed [TEXCOORD_WIDTH-1:0] req_tex_u,
   input  logic signed [TEXCOORD_WIDTH-1:0] req_tex_v,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [tnt_pkg::RES_W-1:0] rsp_normal_x,
   output logic signed [tnt_pkg::RES_W-1:0] rsp_normal_y,
   output logic signed [tnt_pkg::RES_W-1:0] rsp_normal_z,
   output logic signed [tnt_pkg::RES_W-1:0] rsp_tangent_x,
   output logic signed [tnt_pkg::RES_W-1:0] rsp_tangent_y,
   output logic signed [tnt_pkg::RES_W-1:0] rsp_tangent_z,
   output logic                             rsp_normal_degenerate,
   output logic                             rsp_tangent_degenerate
);
   import tnt_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam int TW = TEXCOORD_WIDTH;
   localparam int FB = UNIT_FRAC_BITS;
   localparam int EW = PW + 1;
   localparam int DW = TW + 1;
   localparam int OW = (EW > ROOT_W) ? EW : ROOT_W;
   localparam int AW = 2 * OW + 1;
   localparam int MW = PW + ((PW > TW) ? PW : TW) + 1;
   localparam int VW = (MW > NORM_TOP) ? MW : NORM_TOP;
   localparam int QW = FB + 1;
   localparam int NW = NORM_TOP + QW;

   state_type state_ff, state_in;

   logic [1:0]              corner_ff;
   logic signed [PW-1:0]    held_pos_ff [2][3];
   logic signed [TW-1:0]    held_tex_ff [2][2];
   logic signed [PW-1:0]    pos_in [3];
   logic signed [EW-1:0]    e1_ff [3];
   logic signed [EW-1:0]    e2_ff [3];
   logic signed [DW-1:0]    d1u_ff, d1v_ff, d2u_ff, d2v_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [1:0]              comp_ff;
   logic                    vsel_ff;
   logic signed [OW-1:0]    mul_a, mul_b;
   logic signed [2*OW-1:0]  prod_ff;
   logic signed [AW-1:0]    acc_ff, acc_in;
   logic                    acc_neg;
   logic [AW-1:0]           acc_mag;
   logic [VW-1:0]           vmag_ff [3];
   logic                    vneg_ff [3];
   logic [VW-1:0]           tmag_ff [3];
   logic                    tneg_ff [3];
   logic                    det_neg_ff, det_zero_ff;
   logic [VW-1:0]           vor;
   logic                    vzero, vabove;
   logic [NORM_TOP-1:0]     c_sel;
   logic signed [RES_W-1:0] res_ff [6];
   logic signed [RES_W-1:0] sat;
   logic                    nd_ff, td_ff;
   logic                    rsp_valid_ff;
   logic                    accept, third;
   logic                    out_free;
   logic                    sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]       root;
   logic                    div_start, div_done;
   logic [NW-1:0]           numer;
   logic [QW-1:0]           quot;
   logic [31:0]             qx;

   assign pos_in[0] = req_pos_x;
   assign pos_in[1] = req_pos_y;
   assign pos_in[2] = req_pos_z;

   // Hold the last result while it waits; admit a third corner only when no result waits
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && ((corner_ff != 2'd2) || !rsp_valid_ff);
   assign accept    = req_valid && req_ready;
   assign third     = accept && (corner_ff == 2'd2);

   // Shared multiplier operand select
   assign c_sel = vmag_ff[comp_ff][NORM_TOP-1:0];
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == ST_SQ_MUL) begin
         mul_a = $signed(OW'(c_sel));
         mul_b = $signed(OW'(c_sel));
      end else begin
         unique case (step_ff)
            4'd0:    begin mul_a = OW'(e1_ff[1]); mul_b = OW'(e2_ff[2]); end
            4'd1:    begin mul_a = OW'(e1_ff[2]); mul_b = OW'(e2_ff[1]); end
            4'd2:    begin mul_a = OW'(e1_ff[2]); mul_b = OW'(e2_ff[0]); end
            4'd3:    begin mul_a = OW'(e1_ff[0]); mul_b = OW'(e2_ff[2]); end
            4'd4:    begin mul_a = OW'(e1_ff[0]); mul_b = OW'(e2_ff[1]); end
            4'd5:    begin mul_a = OW'(e1_ff[1]); mul_b = OW'(e2_ff[0]); end
            4'd6:    begin mul_a = OW'(d1u_ff);   mul_b = OW'(d2v_ff);   end
            4'd7:    begin mul_a = OW'(d2u_ff);   mul_b = OW'(d1v_ff);   end
            4'd8:    begin mul_a = OW'(d2v_ff);   mul_b = OW'(e1_ff[0]); end
            4'd9:    begin mul_a = OW'(d1v_ff);   mul_b = OW'(e2_ff[0]); end
            4'd10:   begin mul_a = OW'(d2v_ff);   mul_b = OW'(e1_ff[1]); end
            4'd11:   begin mul_a = OW'(d1v_ff);   mul_b = OW'(e2_ff[1]); end
            4'd12:   begin mul_a = OW'(d2v_ff);   mul_b = OW'(e1_ff[2]); end
            4'd13:   begin mul_a = OW'(d1v_ff);   mul_b = OW'(e2_ff[2]); end
            default: begin mul_a = '0;            mul_b = '0;            end
         endcase
      end
   end

   // Accumulate: load on the first product of a pair, subtract the second; sum the squares
   always_comb begin
      acc_in = acc_ff;
      if (state_ff == ST_ACC) begin
         acc_in = step_ff[0] ? (acc_ff - AW'(prod_ff)) : AW'(prod_ff);
      end else if (state_ff == ST_SQ_ACC) begin
         acc_in = (comp_ff == 2'd0) ? AW'(prod_ff) : (acc_ff + AW'(prod_ff));
      end
   end

   assign acc_neg = acc_ff[AW-1];
   assign acc_mag = acc_neg ? AW'(-acc_ff) : AW'(acc_ff);

   // Scale search inputs
   assign vor    = vmag_ff[0] | vmag_ff[1] | vmag_ff[2];
   assign vzero  = (vor == '0);
   assign vabove = ((vor >> NORM_TOP) != '0);

   // Rounded division numerator and saturation of the signed quotient
   assign numer = NW'({c_sel, {FB{1'b0}}}) + NW'(root >> 1);
   assign qx    = 32'(quot);
   always_comb begin
      if (vneg_ff[comp_ff]) begin
         sat = (qx > 32'd32768) ? 16'sh8000 : 16'(32'd0 - qx);
      end else begin
         sat = (qx > 32'd32767) ? 16'sh7fff : qx[15:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      sqrt_start = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE:      if (third) state_in = ST_MUL;
         ST_MUL:       state_in = (step_ff == 4'd14) ? ST_SCALE : ST_ACC;
         ST_ACC:       state_in = ST_MUL;
         ST_SCALE: begin
            if (vzero) begin
               state_in = ST_NEXT;
            end else if (!vabove && vor[NORM_TOP-1]) begin
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL:    state_in = ST_SQ_ACC;
         ST_SQ_ACC:    state_in = (comp_ff == 2'd2) ? ST_SQRT_GO : ST_SQ_MUL;
         ST_SQRT_GO: begin
            sqrt_start = 1'b1;
            state_in   = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: if (sqrt_done) state_in = ST_DIV_GO;
         ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) state_in = (comp_ff == 2'd2) ? ST_NEXT : ST_DIV_GO;
         end
         ST_NEXT: begin
            if (vsel_ff || det_zero_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Corner count and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_ff    <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            corner_ff <= third ? 2'd0 : corner_ff + 2'd1;
         end
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      acc_ff  <= acc_in;

      // hold the first two corners, form edges on the third
      if (accept && !third) begin
         for (int k = 0; k < 3; k++) begin
            held_pos_ff[corner_ff[0]][k] <= pos_in[k];
         end
         held_tex_ff[corner_ff[0]][0] <= req_tex_u;
         held_tex_ff[corner_ff[0]][1] <= req_tex_v;
      end
      if (third) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= EW'(held_pos_ff[1][k]) - EW'(held_pos_ff[0][k]);
            e2_ff[k] <= EW'(pos_in[k]) - EW'(held_pos_ff[0][k]);
         end
         d1u_ff  <= DW'(held_tex_ff[1][0]) - DW'(held_tex_ff[0][0]);
         d1v_ff  <= DW'(held_tex_ff[1][1]) - DW'(held_tex_ff[0][1]);
         d2u_ff  <= DW'(req_tex_u) - DW'(held_tex_ff[0][0]);
         d2v_ff  <= DW'(req_tex_v) - DW'(held_tex_ff[0][1]);
         step_ff <= '0;
         vsel_ff <= 1'b0;
         nd_ff   <= 1'b0;
         td_ff   <= 1'b0;
      end

      // store the finished pair sum at the next even step
      if (state_ff == ST_MUL) begin
         unique case (step_ff)
            4'd2:  begin vmag_ff[0] <= VW'(acc_mag); vneg_ff[0] <= acc_neg; end
            4'd4:  begin vmag_ff[1] <= VW'(acc_mag); vneg_ff[1] <= acc_neg; end
            4'd6:  begin vmag_ff[2] <= VW'(acc_mag); vneg_ff[2] <= acc_neg; end
            4'd8:  begin det_neg_ff <= acc_neg; det_zero_ff <= (acc_ff == '0); end
            4'd10: begin tmag_ff[0] <= VW'(acc_mag); tneg_ff[0] <= acc_neg ^ det_neg_ff; end
            4'd12: begin tmag_ff[1] <= VW'(acc_mag); tneg_ff[1] <= acc_neg ^ det_neg_ff; end
            4'd14: begin tmag_ff[2] <= VW'(acc_mag); tneg_ff[2] <= acc_neg ^ det_neg_ff; end
            default: ;
         endcase
      end
      if (state_ff == ST_ACC) begin
         step_ff <= step_ff + 1'b1;
      end

      // block-scale one bit per cycle, or flag a zero vector
      if (state_ff == ST_SCALE) begin
         comp_ff <= 2'd0;
         if (vzero) begin
            for (int k = 0; k < 3; k++) begin
               res_ff[vsel_ff ? k + 3 : k] <= '0;
            end
            if (vsel_ff) begin
               td_ff <= 1'b1;
            end else begin
               nd_ff <= 1'b1;
            end
         end else if (vabove) begin
            for (int k = 0; k < 3; k++) vmag_ff[k] <= vmag_ff[k] >> 1;
         end else if (!vor[NORM_TOP-1]) begin
            for (int k = 0; k < 3; k++) vmag_ff[k] <= vmag_ff[k] << 1;
         end
      end

      // advance component over squares and divisions
      if (state_ff == ST_SQ_ACC) begin
         comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
      end
      if (state_ff == ST_DIV_WAIT && div_done) begin
         if (vsel_ff) begin
            res_ff[3 + comp_ff] <= sat;
         end else begin
            res_ff[comp_ff] <= sat;
         end
         comp_ff <= (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
      end

      // switch to the tangent, or drop it on a zero determinant
      if (state_ff == ST_NEXT && !vsel_ff) begin
         vsel_ff <= 1'b1;
         if (det_zero_ff) begin
            td_ff     <= 1'b1;
            res_ff[3] <= '0;
            res_ff[4] <= '0;
            res_ff[5] <= '0;
         end else begin
            for (int k = 0; k < 3; k++) begin
               vmag_ff[k] <= tmag_ff[k];
               vneg_ff[k] <= tneg_ff[k];
            end
         end
      end

      // load the output register
      if (state_ff == ST_OUT && out_free) begin
         rsp_normal_x           <= res_ff[0];
         rsp_normal_y           <= res_ff[1];
         rsp_normal_z           <= res_ff[2];
         rsp_tangent_x          <= res_ff[3];
         rsp_tangent_y          <= res_ff[4];
         rsp_tangent_z          <= res_ff[5];
         rsp_normal_degenerate  <= nd_ff;
         rsp_tangent_degenerate <= td_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   tnt_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (RAD_W'(acc_ff)),
      .done     (sqrt_done),
      .root     (root)
   );

   tnt_div #(
      .QW (QW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer),
      .denom (root),
      .done  (div_done),
      .quot  (quot)
   );

endmodule

// File: rtl/tnt_sqrt.sv
module tnt_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tnt_pkg::RAD_W-1:0]  radicand,
   output logic                       done,
   output logic [tnt_pkg::ROOT_W-1:0] root
);
   import tnt_pkg::*;

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff, root_in;

   // One root bit per cycle, two radicand bits consumed per step
   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      done_in = 1'b0;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (run_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/tnt_div.sv
module tnt_div #(
   parameter int QW = tnt_pkg::UNIT_FRAC_BITS_DEF + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tnt_pkg::NORM_TOP+QW-1:0]   numer,
   input  logic [tnt_pkg::ROOT_W-1:0]        denom,
   output logic                              done,
   output logic [QW-1:0]                     quot
);
   import tnt_pkg::*;

   localparam int REM_W = ROOT_W + 1;
   localparam int CNT_W = $clog2(QW);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in, trial, den_ext;
   logic [QW-1:0]     low_ff, low_in;
   logic [QW-1:0]     quot_ff, quot_in;
   logic [ROOT_W-1:0] den_ff, den_in;

   // Restoring division, one quotient bit per cycle; the quotient fits QW bits
   always_comb begin
      den_ext = {1'b0, den_ff};
      trial   = {rem_ff[REM_W-2:0], low_ff[QW-1]};
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = REM_W'(numer >> QW);
         low_in  = numer[QW-1:0];
         quot_in = '0;
         den_in  = denom;
      end else if (run_ff) begin
         low_in = low_ff << 1;
         if (trial >= den_ext) begin
            rem_in  = trial - den_ext;
            quot_in = {quot_ff[QW-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[QW-2:0], 1'b0};
         end
         if (cnt_ff == CNT_W'(QW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// File: rtl/tnt_checker.sv
module tnt_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [tnt_pkg::RES_W-1:0] rsp_normal_x,
   input logic signed [tnt_pkg::RES_W-1:0] rsp_normal_y,
   input logic signed [tnt_pkg::RES_W-1:0] rsp_normal_z,
   input logic signed [tnt_pkg::RES_W-1:0] rsp_tangent_x,
   input logic signed [tnt_pkg::RES_W-1:0] rsp_tangent_y,
   input logic signed [tnt_pkg::RES_W-1:0] rsp_tangent_z,
   input logic                             rsp_normal_degenerate,
   input logic                             rsp_tangent_degenerate
);

   // No item leaves the block right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled item stays valid and holds its x components and normal flag
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_tangent_x) && $stable(rsp_normal_degenerate))
      else $error("stalled item changed");

   // A degenerate normal is the zero vector
   a_nd_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_normal_degenerate |->
         rsp_normal_x == 0 && rsp_normal_y == 0 && rsp_normal_z == 0)
      else $error("degenerate normal not zero");

   // A degenerate tangent is the zero vector
   a_td_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tangent_degenerate |->
         rsp_tangent_x == 0 && rsp_tangent_y == 0 && rsp_tangent_z == 0)
      else $error("degenerate tangent not zero");

   // A unit normal is never the zero vector
   a_nd_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_normal_degenerate |->
         rsp_normal_x != 0 || rsp_normal_y != 0 || rsp_normal_z != 0)
      else $error("unit normal is zero");

endmodule

bind triangle_normal_tangent tnt_checker u_tnt_checker (.*);

// File: tb/sv/tb_triangle_normal_tangent.sv
module tb_triangle_normal_tangent;
   timeunit 1ns;
   timeprecision 1ps;
   import tnt_pkg::*;

   localparam int PW = POSITION_WIDTH_DEF;
   localparam int TW = TEXCOORD_WIDTH_DEF;
   localparam int FB = UNIT_FRAC_BITS_DEF;
   localparam int N_RANDOM = 1450;
   localparam int WATCHDOG = 20000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct packed {
      logic signed [PW-1:0] px, py, pz;
      logic signed [TW-1:0] tu, tv;
   } corner_t;

   typedef struct packed {
      logic signed [RES_W-1:0] nx, ny, nz, tx, ty, tz;
      logic nd, td;
   } frame_t;

   // directed row: corner plus optional typed-in expectation
   typedef struct {
      corner_t c;
      bit has_exp;
      frame_t exp_val;
   } row_t;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic req_ready, rsp_valid;
   logic signed [PW-1:0] req_pos_x = 0, req_pos_y = 0, req_pos_z = 0;
   logic signed [TW-1:0] req_tex_u = 0, req_tex_v = 0;
   logic signed [RES_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic signed [RES_W-1:0] rsp_tangent_x, rsp_tangent_y, rsp_tangent_z;
   logic rsp_normal_degenerate, rsp_tangent_degenerate;

   triangle_normal_tangent dut (.*);

   always #5 clock = ~clock;

   // predictor state
   int unsigned held_count;
   corner_t held_corner [2];
   frame_t frame_q [$];
   row_t dir [$];
   int errors = 0;
   bit quiet_phase = 0;
   bit long_stall = 0;
   int idle_cycles = 0;

   // normalize an exact 3-vector (value range well inside 128 bits)
   function automatic bit unit_vector(input logic signed [127:0] v [3],
                                      output logic signed [RES_W-1:0] o [3]);
      logic [127:0] m [3];
      logic [63:0] c [3];
      logic [63:0] s, r, rem, one, q;
      logic signed [64:0] sq;
      int len, l;
      len = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i][127] ? -v[i] : v[i];
         l = 0;
         for (int b = 0; b < 128; b++) if (m[i][b]) l = b + 1;
         if (l > len) len = l;
      end
      if (len == 0) begin
         for (int i = 0; i < 3; i++) o[i] = '0;
         return 1'b1;
      end
      s = 0;
      for (int i = 0; i < 3; i++) begin
         if (len > NORM_TOP) c[i] = 64'(m[i] >> (len - NORM_TOP));
         else c[i] = 64'(m[i] << (NORM_TOP - len));
         s += c[i] * c[i];
      end
      // integer square root by digit pairs
      r = 0; rem = s; one = 64'd1 << 62;
      while (one > rem) one >>= 2;
      while (one != 0) begin
         if (rem >= r + one) begin
            rem -= r + one;
            r = (r >> 1) + one;
         end else r >>= 1;
         one >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = ((c[i] << FB) + (r >> 1)) / r;
         sq = $signed({1'b0, q});
         if (v[i][127]) sq = -sq;
         if (sq > 65'sd32767) sq = 65'sd32767;
         if (sq < -65'sd32768) sq = -65'sd32768;
         o[i] = sq[RES_W-1:0];
      end
      return 1'b0;
   endfunction

   // advance the corner buffer; queue the frame on the third corner
   task automatic predict_corner(input corner_t c);
      logic signed [127:0] p0 [3], e1 [3], e2 [3], cr [3], tg [3];
      logic signed [127:0] d1u, d1v, d2u, d2v, det;
      logic signed [RES_W-1:0] n [3], t [3];
      frame_t f;
      if (held_count < 2) begin
         held_corner[held_count] = c;
         held_count++;
         return;
      end
      held_count = 0;
      p0[0] = 128'(held_corner[0].px);
      p0[1] = 128'(held_corner[0].py);
      p0[2] = 128'(held_corner[0].pz);
      e1[0] = 128'(held_corner[1].px) - p0[0];
      e1[1] = 128'(held_corner[1].py) - p0[1];
      e1[2] = 128'(held_corner[1].pz) - p0[2];
      e2[0] = 128'(c.px) - p0[0];
      e2[1] = 128'(c.py) - p0[1];
      e2[2] = 128'(c.pz) - p0[2];
      d1u = 128'(held_corner[1].tu) - 128'(held_corner[0].tu);
      d1v = 128'(held_corner[1].tv) - 128'(held_corner[0].tv);
      d2u = 128'(c.tu) - 128'(held_corner[0].tu);
      d2v = 128'(c.tv) - 128'(held_corner[0].tv);
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      f.nd = unit_vector(cr, n);
      det = d1u * d2v - d2u * d1v;
      if (det == 0) begin
         f.td = 1'b1;
         t[0] = '0; t[1] = '0; t[2] = '0;
      end else begin
         for (int k = 0; k < 3; k++) begin
            tg[k] = d2v * e1[k] - d1v * e2[k];
            if (det < 0) tg[k] = -tg[k];
         end
         f.td = unit_vector(tg, t);
      end
      f.nx = n[0]; f.ny = n[1]; f.nz = n[2];
      f.tx = t[0]; f.ty = t[1]; f.tz = t[2];
      frame_q.insert(frame_q.size(), f);
   endtask

   // append one directed row
   task automatic add_row(input corner_t c, input bit has_exp, input frame_t e);
      row_t r;
      r.c = c;
      r.has_exp = has_exp;
      r.exp_val = e;
      dir.insert(dir.size(), r);
   endtask

   function automatic corner_t mk(int x, int y, int z, int u, int v);
      corner_t c;
      c.px = PW'(x); c.py = PW'(y); c.pz = PW'(z); c.tu = TW'(u); c.tv = TW'(v);
      return c;
   endfunction

   function automatic corner_t rand_corner(input bit small_span);
      corner_t c;
      if (small_span) begin
         c.px = PW'(int'($urandom_range(0, 16383)) - 8192);
         c.py = PW'(int'($urandom_range(0, 16383)) - 8192);
         c.pz = PW'(int'($urandom_range(0, 16383)) - 8192);
         c.tu = TW'(int'($urandom_range(0, 8191)) - 4096);
         c.tv = TW'(int'($urandom_range(0, 8191)) - 4096);
      end else begin
         c.px = PW'($urandom); c.py = PW'($urandom); c.pz = PW'($urandom);
         c.tu = TW'($urandom); c.tv = TW'($urandom);
      end
      return c;
   endfunction

   // send one item, idling before it in random bursts
   task automatic send_corner(input corner_t c);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid <= 1;
      {req_pos_x, req_pos_y, req_pos_z, req_tex_u, req_tex_v} <= c;
      do @(posedge clock); while (!req_ready);
      predict_corner(c);
      @(negedge clock);
   endtask

   // check each accepted frame against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_q.size() == 0) begin
            $error("unexpected item on rsp_");
            errors++;
         end else begin
            frame_t e;
            e = frame_q.pop_front();
            if (rsp_normal_x !== e.nx) begin
               $error("normal_x exp %0d got %0d", e.nx, rsp_normal_x); errors++; end
            if (rsp_normal_y !== e.ny) begin
               $error("normal_y exp %0d got %0d", e.ny, rsp_normal_y); errors++; end
            if (rsp_normal_z !== e.nz) begin
               $error("normal_z exp %0d got %0d", e.nz, rsp_normal_z); errors++; end
            if (rsp_tangent_x !== e.tx) begin
               $error("tangent_x exp %0d got %0d", e.tx, rsp_tangent_x); errors++; end
            if (rsp_tangent_y !== e.ty) begin
               $error("tangent_y exp %0d got %0d", e.ty, rsp_tangent_y); errors++; end
            if (rsp_tangent_z !== e.tz) begin
               $error("tangent_z exp %0d got %0d", e.tz, rsp_tangent_z); errors++; end
            if (rsp_normal_degenerate !== e.nd) begin
               $error("normal_degenerate exp %0d got %0d", e.nd, rsp_normal_degenerate);
               errors++;
            end
            if (rsp_tangent_degenerate !== e.td) begin
               $error("tangent_degenerate exp %0d got %0d", e.td, rsp_tangent_degenerate);
               errors++;
            end
         end
      end
   end

   // receiver: random stall bursts, one long hold-off
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_stall) begin
            rsp_ready <= 0;
            repeat (3000) @(negedge clock);
            long_stall = 0;
         end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("triangle_normal_tangent: mismatch");
         $finish;
      end
   end

   initial begin
      frame_t z;
      int n;
      held_count = 0;
      z = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // all-equal corners: both vectors degenerate
      add_row(mk(0, 0, 0, 0, 0), 1'b0, z);
      add_row(mk(0, 0, 0, 0, 0), 1'b0, z);
      z.nd = 1'b1; z.td = 1'b1;
      add_row(mk(0, 0, 0, 0, 0), 1'b1, z);
      // unit right triangle in xy with uv matching: normal +z, tangent +x
      z = '0; z.nz = 16'sd16384; z.tx = 16'sd16384;
      add_row(mk(0, 0, 0, 0, 0), 1'b0, z);
      add_row(mk(4096, 0, 0, 4096, 0), 1'b0, z);
      add_row(mk(0, 4096, 0, 0, 4096), 1'b1, z);
      // flipped v: negative determinant
      add_row(mk(0, 0, 0, 0, 0), 1'b0, z);
      add_row(mk(4096, 0, 0, 4096, 0), 1'b0, z);
      add_row(mk(0, 4096, 0, 0, -4096), 1'b0, z);
      // parallel edges, zero determinant
      add_row(mk(0, 0, 0, 0, 0), 1'b0, z);
      add_row(mk(100, 200, 300, 5, 5), 1'b0, z);
      add_row(mk(200, 400, 600, 10, 10), 1'b0, z);
      // extremes of positions and texcoords
      add_row(mk(-8388608, -8388608, -8388608, -32768, -32768), 1'b0, z);
      add_row(mk(8388607, -8388608, 8388607, 32767, -32768), 1'b0, z);
      add_row(mk(-8388608, 8388607, 8388607, -32768, 32767), 1'b0, z);
      add_row(mk(8388607, 8388607, 8388607, 32767, 32767), 1'b0, z);
      add_row(mk(-8388608, 8388607, -8388608, 32767, -32768), 1'b0, z);
      add_row(mk(8388607, -8388608, -1, -32768, 32767), 1'b0, z);
      // nonzero det, zero tangent combination: e1 and e2 zero
      add_row(mk(7, 7, 7, 0, 0), 1'b0, z);
      add_row(mk(7, 7, 7, 4096, 0), 1'b0, z);
      add_row(mk(7, 7, 7, 0, 4096), 1'b0, z);

      foreach (dir[i]) begin
         if (dir[i].has_exp && held_count == 2) begin
            send_corner(dir[i].c);
            if (frame_q[$] !== dir[i].exp_val) begin
               $error("typed-in row %0d disagrees with prediction", i);
               errors++;
            end
         end else send_corner(dir[i].c);
      end

      // random triangles; mostly small spans, a few at full range
      n = 0;
      while (n < N_RANDOM) begin
         if (n == 300) long_stall = 1;
         if (n > N_RANDOM - 150) quiet_phase = 1;
         send_corner(rand_corner($urandom_range(0, 4) != 0));
         n++;
      end
      while (held_count != 0) send_corner(rand_corner(1));
      req_valid <= 0;

      while (frame_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) $display("triangle_normal_tangent: match");
      else $display("triangle_normal_tangent: mismatch");
      $finish;
   end
endmodule
